// ===== rtl/tbcu_pkg.sv =====
package tbcu_pkg;

    localparam int MEM_DEPTH_DEF = 2048;
    localparam int IO_DEPTH_DEF  = 32;

    localparam int ADDR_W = 11;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int CODE_W = 5;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // item opcodes
    localparam logic [OP_W-1:0] OP_LOAD_MEM = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_MEM = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_IO  = 2'd2;
    localparam logic [OP_W-1:0] OP_STEP     = 2'd3;

    // instruction codes
    localparam logic [CODE_W-1:0] INS_WM  = 5'h01;
    localparam logic [CODE_W-1:0] INS_RM  = 5'h02;
    localparam logic [CODE_W-1:0] INS_BR  = 5'h03;
    localparam logic [CODE_W-1:0] INS_RIO = 5'h04;
    localparam logic [CODE_W-1:0] INS_WIO = 5'h05;
    localparam logic [CODE_W-1:0] INS_WB  = 5'h06;
    localparam logic [CODE_W-1:0] INS_WIB = 5'h07;
    localparam logic [CODE_W-1:0] INS_EOP = 5'h1F;

    // run status
    localparam logic [STAT_W-1:0] STAT_RUN = 2'd0;
    localparam logic [STAT_W-1:0] STAT_END = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERR = 2'd2;

    typedef struct packed {
        logic              mem_we;
        logic [ADDR_W-1:0] mem_addr;
        logic [BYTE_W-1:0] mem_wdata;
        logic              io_we;
        logic [ADDR_W-1:0] io_addr;
        logic [BYTE_W-1:0] io_wdata;
    } mem_req_t;

endpackage

// ===== rtl/tiny_bus_cpu_control_unit.sv =====
// Byte-memory processor: main memory of MEM_DEPTH bytes and an I/O store of IO_DEPTH bytes,
// each a single-port synchronous RAM. After reset both stores are cleared in one pass over
// max(MEM_DEPTH, IO_DEPTH) addresses, during which s_ready stays low. One transaction is worked
// on at a time and yields one result; how long it takes is set by the memory port and the
// address reduction: a halted step goes straight to its result, literal, end and unknown-code
// steps end after the fetch, load and io/memory reads after the reduction and data access, and
// memory, branch or io steps run fetch of two bytes, operand reduction and data access. A
// result left waiting in the output register delays the next one, not the next acceptance.
module tiny_bus_cpu_control_unit #(
    parameter int MEM_DEPTH = tbcu_pkg::MEM_DEPTH_DEF,
    parameter int IO_DEPTH  = tbcu_pkg::IO_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tbcu_pkg::OP_W-1:0]    s_opcode,
    input  logic [tbcu_pkg::ADDR_W-1:0]  s_address,
    input  logic [tbcu_pkg::BYTE_W-1:0]  s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tbcu_pkg::BYTE_W-1:0]  m_read_data,
    output logic [tbcu_pkg::ADDR_W-1:0]  m_pc_value,
    output logic [tbcu_pkg::WORD_W-1:0]  m_instr_word,
    output logic [tbcu_pkg::BYTE_W-1:0]  m_mbr_value,
    output logic [tbcu_pkg::BYTE_W-1:0]  m_iobr_value,
    output logic [tbcu_pkg::STAT_W-1:0]  m_status
);
    import tbcu_pkg::*;

    localparam int MEM_AW  = $clog2(MEM_DEPTH);
    localparam int IO_AW   = $clog2(IO_DEPTH);
    localparam int CLR_LEN = (MEM_DEPTH > IO_DEPTH) ? MEM_DEPTH : IO_DEPTH;
    localparam int CLR_W   = $clog2(CLR_LEN);

    mem_req_t          mem_req;
    logic [BYTE_W-1:0] mem_rdata;
    logic [BYTE_W-1:0] io_rdata;
    logic              clear_busy_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              io_we;
    logic [IO_AW-1:0]  io_addr;
    logic [BYTE_W-1:0] io_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else if (clear_busy_reg) begin
            if (clr_cnt_reg == CLR_W'(CLR_LEN - 1)) begin
                clear_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // clearing pass owns both ports until it finishes
    always_comb begin
        if (clear_busy_reg) begin
            mem_we    = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(MEM_DEPTH));
            mem_addr  = clr_cnt_reg[MEM_AW-1:0];
            mem_wdata = '0;
            io_we     = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(IO_DEPTH));
            io_addr   = clr_cnt_reg[IO_AW-1:0];
            io_wdata  = '0;
        end else begin
            mem_we    = mem_req.mem_we;
            mem_addr  = mem_req.mem_addr[MEM_AW-1:0];
            mem_wdata = mem_req.mem_wdata;
            io_we     = mem_req.io_we;
            io_addr   = mem_req.io_addr[IO_AW-1:0];
            io_wdata  = mem_req.io_wdata;
        end
    end

    tbcu_ram #(.WIDTH(BYTE_W), .DEPTH(MEM_DEPTH)) u_main_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    tbcu_ram #(.WIDTH(BYTE_W), .DEPTH(IO_DEPTH)) u_io_mem (
        .aclk  (aclk),
        .we    (io_we),
        .addr  (io_addr),
        .wdata (io_wdata),
        .rdata (io_rdata)
    );

    tbcu_core #(.MEM_DEPTH(MEM_DEPTH), .IO_DEPTH(IO_DEPTH)) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear_busy   (clear_busy_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_address    (s_address),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_pc_value   (m_pc_value),
        .m_instr_word (m_instr_word),
        .m_mbr_value  (m_mbr_value),
        .m_iobr_value (m_iobr_value),
        .m_status     (m_status),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .io_rdata     (io_rdata)
    );

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !s_ready)
        else $error("transaction accepted during clearing pass");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while one is in progress");

    a_no_core_write_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !(mem_req.mem_we || mem_req.io_we))
        else $error("core store write during clearing pass");
`endif

endmodule

// ===== rtl/tbcu_ram.sv =====
module tbcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/tbcu_modred.sv =====
module tbcu_modred #(
    parameter int DIV = 32
) (
    input  logic                          aclk,
    input  logic [tbcu_pkg::ADDR_W-1:0]   a_in,
    output logic [$clog2(DIV)-1:0]        rem_out
);
    import tbcu_pkg::*;

    // a mod DIV by reciprocal: q estimate is low by at most one
    localparam int OUT_W = $clog2(DIV);
    localparam int SHIFT = 22;
    localparam int PROD_W = ADDR_W + SHIFT + 1;
    localparam int R_W = ADDR_W + 1;
    localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'((1 << SHIFT) / DIV);

    logic [ADDR_W-1:0] a_reg;
    logic [ADDR_W-1:0] q_reg;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] qd;
    logic [PROD_W-1:0] diff;
    logic [R_W-1:0]    r_raw;
    logic [R_W-1:0]    r_next;

    assign prod   = PROD_W'(a_in) * PROD_W'(RECIP);
    assign qd     = PROD_W'(q_reg) * PROD_W'(DIV);
    assign diff   = PROD_W'(a_reg) - qd;
    assign r_raw  = diff[R_W-1:0];
    assign r_next = (r_raw >= R_W'(DIV)) ? r_raw - R_W'(DIV) : r_raw;

    always_ff @(posedge aclk) begin
        a_reg   <= a_in;
        q_reg   <= prod[SHIFT +: ADDR_W];
        rem_out <= r_next[OUT_W-1:0];
    end

endmodule

// ===== rtl/tbcu_core.sv =====
module tbcu_core #(
    parameter int MEM_DEPTH = tbcu_pkg::MEM_DEPTH_DEF,
    parameter int IO_DEPTH  = tbcu_pkg::IO_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear_busy,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tbcu_pkg::OP_W-1:0]    s_opcode,
    input  logic [tbcu_pkg::ADDR_W-1:0]  s_address,
    input  logic [tbcu_pkg::BYTE_W-1:0]  s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tbcu_pkg::BYTE_W-1:0]  m_read_data,
    output logic [tbcu_pkg::ADDR_W-1:0]  m_pc_value,
    output logic [tbcu_pkg::WORD_W-1:0]  m_instr_word,
    output logic [tbcu_pkg::BYTE_W-1:0]  m_mbr_value,
    output logic [tbcu_pkg::BYTE_W-1:0]  m_iobr_value,
    output logic [tbcu_pkg::STAT_W-1:0]  m_status,
    output tbcu_pkg::mem_req_t           mem_req,
    input  logic [tbcu_pkg::BYTE_W-1:0]  mem_rdata,
    input  logic [tbcu_pkg::BYTE_W-1:0]  io_rdata
);
    import tbcu_pkg::*;

    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int IO_AW  = $clog2(IO_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH_HI,
        S_FETCH_LO,
        S_MOD1,
        S_MOD2,
        S_RD_WAIT,
        S_RESULT
    } state_t;

    state_t            state_reg;
    logic [MEM_AW-1:0] pc_reg;
    logic [WORD_W-1:0] instr_reg;
    logic [BYTE_W-1:0] mbr_reg;
    logic [BYTE_W-1:0] iobr_reg;
    logic [STAT_W-1:0] status_reg;
    logic [BYTE_W-1:0] hi_reg;
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] rd_reg;
    logic              m_valid_reg;

    logic [ADDR_W-1:0] mod_in;
    logic [MEM_AW-1:0] mem_rem;
    logic [IO_AW-1:0]  io_rem;
    logic [MEM_AW-1:0] pc1;
    logic [MEM_AW-1:0] pc2;
    logic [CODE_W-1:0] code;
    logic              accept;
    logic              out_free;

    function automatic logic [MEM_AW-1:0] inc_wrap(input logic [MEM_AW-1:0] v);
        inc_wrap = (v == MEM_AW'(MEM_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    assign s_ready  = (state_reg == S_IDLE) && !clear_busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign pc1      = inc_wrap(pc_reg);
    assign pc2      = inc_wrap(pc1);
    assign code     = instr_reg[WORD_W-1 -: CODE_W];

    // operand low bits straight off the read port during the second fetch
    assign mod_in = (state_reg == S_IDLE) ? s_address : {hi_reg[2:0], mem_rdata};

    tbcu_modred #(.DIV(MEM_DEPTH)) u_mem_mod (
        .aclk    (aclk),
        .a_in    (mod_in),
        .rem_out (mem_rem)
    );

    tbcu_modred #(.DIV(IO_DEPTH)) u_io_mod (
        .aclk    (aclk),
        .a_in    (mod_in),
        .rem_out (io_rem)
    );

    always_comb begin
        mem_req.mem_we    = 1'b0;
        mem_req.mem_addr  = ADDR_W'(pc_reg);
        mem_req.mem_wdata = (op_reg == OP_LOAD_MEM) ? data_reg : mbr_reg;
        mem_req.io_we     = 1'b0;
        mem_req.io_addr   = ADDR_W'(io_rem);
        mem_req.io_wdata  = iobr_reg;
        case (state_reg)
            S_FETCH_HI: begin
                mem_req.mem_addr = ADDR_W'(pc1);
            end
            S_MOD2: begin
                mem_req.mem_addr = ADDR_W'(mem_rem);
                if (op_reg == OP_LOAD_MEM) begin
                    mem_req.mem_we = 1'b1;
                end else if (op_reg == OP_STEP) begin
                    mem_req.mem_we = (code == INS_WM);
                    mem_req.io_we  = (code == INS_WIO);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            instr_reg   <= '0;
            mbr_reg     <= '0;
            iobr_reg    <= '0;
            status_reg  <= STAT_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            // in S_RESULT the output register is reloaded below
            if (m_valid_reg && m_ready && state_reg != S_RESULT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg   <= s_opcode;
                        data_reg <= s_data;
                        rd_reg   <= '0;
                        if (s_opcode != OP_STEP) begin
                            state_reg <= S_MOD1;
                        end else if (status_reg == STAT_RUN) begin
                            state_reg <= S_FETCH_HI;
                        end else begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_FETCH_HI: begin
                    hi_reg    <= mem_rdata;
                    state_reg <= S_FETCH_LO;
                end
                S_FETCH_LO: begin
                    instr_reg <= {hi_reg, mem_rdata};
                    pc_reg    <= pc2;
                    case (hi_reg[BYTE_W-1 -: CODE_W])
                        INS_WM, INS_RM, INS_BR, INS_RIO, INS_WIO: begin
                            state_reg <= S_MOD1;
                        end
                        INS_WB: begin
                            mbr_reg   <= mem_rdata;
                            state_reg <= S_RESULT;
                        end
                        INS_WIB: begin
                            iobr_reg  <= mem_rdata;
                            state_reg <= S_RESULT;
                        end
                        INS_EOP: begin
                            status_reg <= STAT_END;
                            state_reg  <= S_RESULT;
                        end
                        default: begin
                            status_reg <= STAT_ERR;
                            state_reg  <= S_RESULT;
                        end
                    endcase
                end
                S_MOD1: begin
                    state_reg <= S_MOD2;
                end
                S_MOD2: begin
                    if (op_reg == OP_READ_MEM || op_reg == OP_READ_IO) begin
                        state_reg <= S_RD_WAIT;
                    end else if (op_reg == OP_STEP && (code == INS_RM || code == INS_RIO)) begin
                        state_reg <= S_RD_WAIT;
                    end else begin
                        state_reg <= S_RESULT;
                    end
                    if (op_reg == OP_STEP && code == INS_BR) begin
                        pc_reg <= mem_rem;
                    end
                end
                S_RD_WAIT: begin
                    state_reg <= S_RESULT;
                    case (op_reg)
                        OP_READ_MEM: rd_reg <= mem_rdata;
                        OP_READ_IO:  rd_reg <= io_rdata;
                        OP_STEP: begin
                            if (code == INS_RM) begin
                                mbr_reg <= mem_rdata;
                            end else begin
                                iobr_reg <= io_rdata;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_RESULT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_read_data  <= rd_reg;
                        m_pc_value   <= ADDR_W'(pc_reg);
                        m_instr_word <= instr_reg;
                        m_mbr_value  <= mbr_reg;
                        m_iobr_value <= iobr_reg;
                        m_status     <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
